// File: src/apu_pkg.sv
// Package: shared types and register offsets for the APU frame sequencer
`timescale 1ns / 1ps
package apu_pkg;
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [7:0] ADDR_NR10 = 8'h10;
  localparam logic [7:0] ADDR_NR11 = 8'h11;
  localparam logic [7:0] ADDR_NR12 = 8'h12;
  localparam logic [7:0] ADDR_NR13 = 8'h13;
  localparam logic [7:0] ADDR_NR14 = 8'h14;
  localparam logic [7:0] ADDR_NR21 = 8'h16;
  localparam logic [7:0] ADDR_NR22 = 8'h17;
  localparam logic [7:0] ADDR_NR23 = 8'h18;
  localparam logic [7:0] ADDR_NR24 = 8'h19;
  localparam logic [7:0] ADDR_NR30 = 8'h1A;
  localparam logic [7:0] ADDR_NR31 = 8'h1B;
  localparam logic [7:0] ADDR_NR32 = 8'h1C;
  localparam logic [7:0] ADDR_NR33 = 8'h1D;
  localparam logic [7:0] ADDR_NR34 = 8'h1E;
  localparam logic [7:0] ADDR_NR41 = 8'h20;
  localparam logic [7:0] ADDR_NR42 = 8'h21;
  localparam logic [7:0] ADDR_NR43 = 8'h22;
  localparam logic [7:0] ADDR_NR44 = 8'h23;
  localparam logic [7:0] ADDR_NR50 = 8'h24;
  localparam logic [7:0] ADDR_NR51 = 8'h25;
  localparam logic [7:0] ADDR_NR52 = 8'h26;
  localparam logic [7:0] ADDR_WAVE = 8'h30;

  localparam logic [16:0] ACC_MAX = 17'h1FFFF;
  localparam logic [11:0] FREQ_MAX = 12'd2047;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  channel_enabled;
    logic [3:0]  square1_volume;
    logic [3:0]  square2_volume;
    logic [3:0]  noise_volume;
    logic [10:0] square1_frequency;
    logic [10:0] square2_frequency;
    logic [10:0] wave_frequency;
    logic [3:0]  square_duty_codes;
    logic [1:0]  wave_level_code;
    logic [7:0]  noise_settings;
    logic [7:0]  mix_enables;
  } result_t;

  // Frame clocks for one sequencer step
  typedef struct packed {
    logic len;
    logic sweep;
    logic env;
  } frame_clk_t;
endpackage

// File: src/apu_stream_if.sv
// Interface: valid/ready channel carrying one payload
`timescale 1ns / 1ps
interface apu_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/apu_register_frame_sequencer.sv
// Top level: APU register file, frame sequencer and result register
`timescale 1ns / 1ps
// The result is registered: it appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; input accepted while the result
// register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): master on, routing 0xFF, frame step 8192,
// all other state cleared and wave RAM entries marked unwritten; no result pending.
module apu_register_frame_sequencer #(
  parameter int WAVE_RAM_BYTES = 16
) (
  input logic clk,
  input logic rst_n,
  apu_stream_if.sink   in_ch,
  apu_stream_if.source out_ch,
  apu_stream_if.sink   cfg_ch
);
  localparam int WA = $clog2(WAVE_RAM_BYTES);

  apu_pkg::item_t   it;
  apu_pkg::result_t res;
  logic out_valid_r;
  logic fire;

  assign it = apu_pkg::item_t'(in_ch.data);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res;

  // Architectural state
  logic [15:0] step_cycles_r;
  logic        master_r;
  logic [16:0] acc_r;
  logic [2:0]  seq_r;
  logic [7:0]  len_r [4];
  logic [3:0]  len_en_r;
  logic [3:0]  on_r;
  logic [10:0] freq_r [3];
  logic [6:0]  sw_setup_r;
  logic [11:0] shadow_r;
  logic [2:0]  sw_timer_r;
  logic        sw_active_r;
  logic [1:0]  duty_r [2];
  logic [1:0]  wlevel_r;
  logic [7:0]  noise_r;
  logic [7:0]  spk_r;
  logic [7:0]  route_r;
  logic [7:0]  wave_ram [WAVE_RAM_BYTES];
  logic [WAVE_RAM_BYTES-1:0] wave_vld_r;

  logic is_wr, is_rd, is_tick, wr_on;
  assign is_wr   = fire && it.req_type == apu_pkg::REQ_WRITE;
  assign is_rd   = it.req_type == apu_pkg::REQ_READ;
  assign is_tick = fire && it.req_type == apu_pkg::REQ_TICK && master_r;
  assign wr_on   = is_wr && master_r && it.reg_address != apu_pkg::ADDR_NR52;

  // Accumulate cycles, saturate, and decide on one sequencer step
  logic [17:0] sum_raw;
  logic [16:0] sum_sat;
  logic        step_go;
  logic [2:0]  seq_nxt;
  apu_pkg::frame_clk_t fclk;
  assign sum_raw = {1'b0, acc_r} + {10'd0, it.tick_cycles};
  assign sum_sat = sum_raw[17] ? apu_pkg::ACC_MAX : sum_raw[16:0];
  assign step_go = is_tick && (sum_sat > {1'b0, step_cycles_r});
  assign seq_nxt = seq_r + 3'd1;
  always_comb begin
    fclk = '0;
    if (step_go) begin
      fclk.len   = !seq_nxt[0];
      fclk.sweep = seq_nxt == 3'd2 || seq_nxt == 3'd6;
      fclk.env   = seq_nxt == 3'd7;
    end
  end

  // Sweep arithmetic
  logic [2:0]  sw_tdec;
  logic [11:0] sw_delta, sw_next;
  logic        sw_fire, sw_ovf;
  assign sw_tdec  = sw_timer_r - 3'd1;
  assign sw_delta = shadow_r >> sw_setup_r[2:0];
  assign sw_next  = sw_setup_r[3] ? ((shadow_r >= sw_delta) ? shadow_r - sw_delta : 12'd0)
                                  : shadow_r + sw_delta;
  assign sw_fire  = fclk.sweep && sw_setup_r[6:4] != 3'd0 && sw_tdec == 3'd0 && sw_active_r;
  assign sw_ovf   = sw_next > apu_pkg::FREQ_MAX;

  // Envelopes: square 1, square 2, noise
  logic [7:0] env_setup [3];
  logic [3:0] env_level [3];
  logic [2:0] env_load;
  logic [7:0] env_val;
  assign env_val = rst_n ? it.write_data : 8'd0;
  assign env_load[0] = !rst_n || (wr_on && it.reg_address == apu_pkg::ADDR_NR12);
  assign env_load[1] = !rst_n || (wr_on && it.reg_address == apu_pkg::ADDR_NR22);
  assign env_load[2] = !rst_n || (wr_on && it.reg_address == apu_pkg::ADDR_NR42);
  for (genvar e = 0; e < 3; e++) begin : g_env
    apu_envelope u_env (
      .clk(clk), .load(env_load[e]), .load_val(env_val), .step(fclk.env),
      .setup(env_setup[e]), .level(env_level[e])
    );
  end

  logic        wave_hit;
  logic [WA-1:0] wave_idx;
  assign wave_hit = it.reg_address >= apu_pkg::ADDR_WAVE
                 && {1'b0, it.reg_address} < {1'b0, apu_pkg::ADDR_WAVE} + 9'(WAVE_RAM_BYTES);
  assign wave_idx = WA'(it.reg_address - apu_pkg::ADDR_WAVE);

  // Wave RAM: entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (wr_on && wave_hit) wave_ram[wave_idx] <= it.write_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cycles_r <= 16'd8192;
      master_r <= 1'b1;
      acc_r <= '0; seq_r <= '0;
      for (int c = 0; c < 4; c++) len_r[c] <= '0;
      len_en_r <= '0; on_r <= '0;
      for (int c = 0; c < 3; c++) freq_r[c] <= '0;
      sw_setup_r <= '0; shadow_r <= '0; sw_timer_r <= '0; sw_active_r <= 1'b0;
      duty_r[0] <= '0; duty_r[1] <= '0;
      wlevel_r <= '0; noise_r <= '0; spk_r <= '0; route_r <= 8'hFF;
      wave_vld_r <= '0;
    end else begin
      if (cfg_ch.valid) step_cycles_r <= cfg_ch.data[15:0];
      if (is_wr && it.reg_address == apu_pkg::ADDR_NR52) master_r <= it.write_data[7];
      if (is_tick) acc_r <= step_go ? sum_sat - {1'b0, step_cycles_r} : sum_sat;
      if (step_go) seq_r <= seq_nxt;
      // Length counters
      if (fclk.len) begin
        for (int c = 0; c < 4; c++) begin
          if (len_en_r[c] && len_r[c] != 8'd0) begin
            len_r[c] <= len_r[c] - 8'd1;
            if (len_r[c] == 8'd1) on_r[c] <= 1'b0;
          end
        end
      end
      // Sweep
      if (fclk.sweep && sw_setup_r[6:4] != 3'd0) begin
        sw_timer_r <= (sw_tdec == 3'd0) ? sw_setup_r[6:4] : sw_tdec;
        if (sw_fire) begin
          if (sw_ovf) on_r[0] <= 1'b0;
          else begin
            shadow_r <= sw_next;
            freq_r[0] <= sw_next[10:0];
          end
        end
      end
      if (wr_on) begin
        unique case (it.reg_address)
          apu_pkg::ADDR_NR10: sw_setup_r <= it.write_data[6:0];
          apu_pkg::ADDR_NR11: begin
            duty_r[0] <= it.write_data[7:6]; len_r[0] <= {2'b0, it.write_data[5:0]};
          end
          apu_pkg::ADDR_NR13: freq_r[0][7:0] <= it.write_data;
          apu_pkg::ADDR_NR14: begin
            if (it.write_data[7]) begin
              on_r[0] <= 1'b1; len_r[0] <= 8'd63;
              freq_r[0][10:8] <= it.write_data[2:0];
              shadow_r <= {1'b0, it.write_data[2:0], freq_r[0][7:0]};
              sw_timer_r <= sw_setup_r[6:4];
              if (sw_setup_r[6:4] != 3'd0 || sw_setup_r[2:0] != 3'd0) sw_active_r <= 1'b1;
            end
            len_en_r[0] <= it.write_data[6];
          end
          apu_pkg::ADDR_NR21: begin
            duty_r[1] <= it.write_data[7:6]; len_r[1] <= {2'b0, it.write_data[5:0]};
          end
          apu_pkg::ADDR_NR23: freq_r[1][7:0] <= it.write_data;
          apu_pkg::ADDR_NR24: begin
            if (it.write_data[7]) begin on_r[1] <= 1'b1; len_r[1] <= 8'd63; end
            len_en_r[1] <= it.write_data[6];
            freq_r[1][10:8] <= it.write_data[2:0];
          end
          apu_pkg::ADDR_NR30: on_r[2] <= it.write_data != 8'd0;
          apu_pkg::ADDR_NR31: len_r[2] <= it.write_data;
          apu_pkg::ADDR_NR32: wlevel_r <= it.write_data[6:5];
          apu_pkg::ADDR_NR33: freq_r[2][7:0] <= it.write_data;
          apu_pkg::ADDR_NR34: begin
            if (it.write_data[7]) begin on_r[2] <= 1'b1; len_r[2] <= 8'hFF; end
            len_en_r[2] <= it.write_data[6];
            freq_r[2][10:8] <= it.write_data[2:0];
          end
          apu_pkg::ADDR_NR41: len_r[3] <= it.write_data;
          apu_pkg::ADDR_NR43: noise_r <= it.write_data;
          apu_pkg::ADDR_NR44: begin
            if (it.write_data[7]) begin on_r[3] <= 1'b1; len_r[3] <= 8'hFF; end
            len_en_r[3] <= it.write_data[6];
          end
          apu_pkg::ADDR_NR50: spk_r <= it.write_data;
          apu_pkg::ADDR_NR51: route_r <= it.write_data;
          default: if (wave_hit) wave_vld_r[wave_idx] <= 1'b1;
        endcase
      end
    end
  end

  // Read mux
  logic [7:0] rd;
  always_comb begin
    rd = 8'd0;
    if (is_rd) begin
      if (it.reg_address == apu_pkg::ADDR_NR52) begin
        rd = {master_r, 3'b000, len_r[3] != 8'd0, len_r[2] != 8'd0,
              len_r[1] != 8'd0, len_r[0] != 8'd0};
      end else if (master_r) begin
        unique case (it.reg_address)
          apu_pkg::ADDR_NR10: rd = {1'b0, sw_setup_r};
          apu_pkg::ADDR_NR11: rd = {duty_r[0], 6'h3F};
          apu_pkg::ADDR_NR12: rd = env_setup[0];
          apu_pkg::ADDR_NR14: rd = {1'b1, len_en_r[0], 6'h3F};
          apu_pkg::ADDR_NR21: rd = {duty_r[1], 6'h3F};
          apu_pkg::ADDR_NR22: rd = env_setup[1];
          apu_pkg::ADDR_NR24: rd = {1'b1, len_en_r[1], 6'h3F};
          apu_pkg::ADDR_NR30: rd = {7'h7F, on_r[2]};
          apu_pkg::ADDR_NR31: rd = len_r[2];
          apu_pkg::ADDR_NR32: rd = {1'b1, wlevel_r, 5'h1F};
          apu_pkg::ADDR_NR34: rd = {1'b1, len_en_r[2], 6'h3F};
          apu_pkg::ADDR_NR41: rd = len_r[3];
          apu_pkg::ADDR_NR42: rd = env_setup[2];
          apu_pkg::ADDR_NR43: rd = noise_r;
          apu_pkg::ADDR_NR44: rd = {1'b1, len_en_r[3], 6'h3F};
          apu_pkg::ADDR_NR50: rd = spk_r;
          apu_pkg::ADDR_NR51: rd = route_r;
          apu_pkg::ADDR_NR13, apu_pkg::ADDR_NR23, apu_pkg::ADDR_NR33: rd = 8'hFF;
          default: if (wave_hit && wave_vld_r[wave_idx]) rd = wave_ram[wave_idx];
        endcase
      end
    end
  end

  // Result: snapshot of state as it will stand after this transaction.
  // Fields that change this cycle are taken from their registers in the cycle after,
  // so capture read data now and sample the rest after the update.
  logic [7:0] rd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (fire) rd_r <= rd;
  end

  // Parameters reflect post-transaction state, which the registers hold now;
  // while a result waits, no new transaction is accepted, so they stay put.
  always_comb begin
    res.read_data         = rd_r;
    res.channel_enabled   = on_r;
    res.square1_volume    = env_level[0];
    res.square2_volume    = env_level[1];
    res.noise_volume      = env_level[2];
    res.square1_frequency = freq_r[0];
    res.square2_frequency = freq_r[1];
    res.wave_frequency    = freq_r[2];
    res.square_duty_codes = {duty_r[1], duty_r[0]};
    res.wave_level_code   = wlevel_r;
    res.noise_settings    = noise_r;
    res.mix_enables       = route_r;
  end

  a_len_off: assert property (@(posedge clk) disable iff (!rst_n)
    fclk.len && len_en_r[1] && len_r[1] == 8'd1 && !wr_on |=> !on_r[1])
    else $error("length expiry left channel 2 on");
  a_seq_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> seq_r == $past(seq_nxt))
    else $error("sequencer did not advance");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(rd_r))
    else $error("pending result lost");
endmodule

// File: src/apu_envelope.sv
// Volume envelope: one channel's level and period counter
`timescale 1ns / 1ps
module apu_envelope (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_val,
  input  logic       step,
  output logic [7:0] setup,
  output logic [3:0] level
);
  logic [7:0] setup_r;
  logic [2:0] cnt_r;
  logic [3:0] level_r;
  logic [2:0] cnt_dec;

  assign cnt_dec = cnt_r - 3'd1;
  assign setup = setup_r;
  assign level = level_r;

  // Reset values are loaded through load by the parent (setup 0)
  always_ff @(posedge clk) begin
    if (load) begin
      setup_r <= load_val;
      cnt_r   <= load_val[2:0];
      level_r <= load_val[7:4];
    end else if (step && setup_r[2:0] != 3'd0) begin
      if (cnt_dec == 3'd0) begin
        cnt_r <= setup_r[2:0];
        if (setup_r[3] && level_r != 4'd15) level_r <= level_r + 4'd1;
        else if (!setup_r[3] && level_r != 4'd0) level_r <= level_r - 4'd1;
      end else begin
        cnt_r <= cnt_dec;
      end
    end
  end
endmodule

// File: tb/sv/testbench.sv
// Testbench for the APU register file and frame sequencer, self-checking
`timescale 1ns / 1ps
module testbench;
  import apu_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 650;

  logic clk;
  logic rst_n;

  apu_stream_if #(.W($bits(item_t)))   in_if ();
  apu_stream_if #(.W($bits(result_t))) out_if ();
  apu_stream_if #(.W(16))              cfg_if ();

  apu_register_frame_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow copy of the block state, kept in step with every accepted transaction
  logic [15:0] frame_len;
  logic        master_en;
  logic [16:0] cyc_acc;
  logic [2:0]  seq_step;
  logic [7:0]  len_cnt [4];
  logic        len_en [4];
  logic        chan_on [4];
  logic [7:0]  env_cfg [3];
  logic [2:0]  env_cnt [3];
  logic [3:0]  env_lvl [3];
  logic [10:0] freq [3];
  logic [6:0]  sweep_cfg;
  logic [11:0] sweep_shadow;
  logic [2:0]  sweep_tmr;
  logic        sweep_on;
  logic [1:0]  duty [2];
  logic [1:0]  wave_lvl;
  logic [7:0]  noise_cfg;
  logic [7:0]  speaker;
  logic [7:0]  routing;
  logic [7:0]  wave_mem [16];

  result_t expected_results[$];
  int      cycle_count;
  int      fail_count;
  int      items_sent;
  int      results_seen;
  int      burst_left;
  int      seq_steps_seen;

  // Mapped register offsets, used to aim random traffic at real registers
  logic [7:0] reg_map [21] = '{ADDR_NR10, ADDR_NR11, ADDR_NR12, ADDR_NR13, ADDR_NR14,
                               ADDR_NR21, ADDR_NR22, ADDR_NR23, ADDR_NR24, ADDR_NR30,
                               ADDR_NR31, ADDR_NR32, ADDR_NR33, ADDR_NR34, ADDR_NR41,
                               ADDR_NR42, ADDR_NR43, ADDR_NR44, ADDR_NR50, ADDR_NR51,
                               ADDR_NR52};

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: fail the run once the cycle limit is exceeded
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic reset_shadow();
    frame_len = 16'd8192;
    master_en = 1'b1;
    cyc_acc = '0;
    seq_step = '0;
    for (int i = 0; i < 4; i++) begin
      len_cnt[i] = '0;
      len_en[i] = 1'b0;
      chan_on[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      env_cfg[i] = '0;
      env_cnt[i] = '0;
      env_lvl[i] = '0;
      freq[i] = '0;
    end
    sweep_cfg = '0;
    sweep_shadow = '0;
    sweep_tmr = '0;
    sweep_on = 1'b0;
    duty[0] = '0;
    duty[1] = '0;
    wave_lvl = '0;
    noise_cfg = '0;
    speaker = '0;
    routing = 8'hFF;
    for (int i = 0; i < 16; i++) wave_mem[i] = '0;
  endtask

  function automatic void clock_lengths();
    for (int c = 0; c < 4; c++) begin
      if (len_en[c] && len_cnt[c] != 0) begin
        len_cnt[c] = len_cnt[c] - 8'd1;
        if (len_cnt[c] == 0) chan_on[c] = 1'b0;
      end
    end
  endfunction

  function automatic void clock_envelopes();
    for (int e = 0; e < 3; e++) begin
      // period 0 leaves the envelope frozen
      if (env_cfg[e][2:0] != 0) begin
        env_cnt[e] = env_cnt[e] - 3'd1;
        if (env_cnt[e] == 0) begin
          env_cnt[e] = env_cfg[e][2:0];
          if (env_cfg[e][3] && env_lvl[e] < 4'd15) env_lvl[e] = env_lvl[e] + 4'd1;
          else if (!env_cfg[e][3] && env_lvl[e] > 0) env_lvl[e] = env_lvl[e] - 4'd1;
        end
      end
    end
  endfunction

  function automatic void clock_sweep();
    logic [11:0] delta;
    int          nxt;
    if (sweep_cfg[6:4] == 0) return;
    sweep_tmr = sweep_tmr - 3'd1;
    if (sweep_tmr != 0) return;
    sweep_tmr = sweep_cfg[6:4];
    if (!sweep_on) return;
    delta = sweep_shadow >> sweep_cfg[2:0];
    if (sweep_cfg[3]) nxt = (sweep_shadow >= delta) ? int'(sweep_shadow) - int'(delta) : 0;
    else nxt = int'(sweep_shadow) + int'(delta);
    // overflow kills channel one and keeps the old frequency
    if (nxt > int'(FREQ_MAX)) chan_on[0] = 1'b0;
    else begin
      sweep_shadow = nxt[11:0];
      freq[0] = nxt[10:0];
    end
  endfunction

  function automatic void tick_time(logic [7:0] cyc);
    int sum;
    sum = int'(cyc_acc) + int'(cyc);
    if (sum > int'(ACC_MAX)) sum = int'(ACC_MAX);
    cyc_acc = sum[16:0];
    if (cyc_acc <= {1'b0, frame_len}) return;
    cyc_acc = cyc_acc - {1'b0, frame_len};
    seq_step = seq_step + 3'd1;
    seq_steps_seen++;
    case (seq_step)
      3'd0, 3'd4: begin
        clock_lengths();
      end
      3'd2, 3'd6: begin
        clock_lengths();
        clock_sweep();
      end
      3'd7: begin
        clock_envelopes();
      end
      default: ;
    endcase
  endfunction

  function automatic void write_register(logic [7:0] a, logic [7:0] v);
    if (a == ADDR_NR52) begin
      master_en = v[7];
      return;
    end
    if (!master_en) return;
    case (a)
      ADDR_NR10: sweep_cfg = v[6:0];
      ADDR_NR11: begin
        duty[0] = v[7:6];
        len_cnt[0] = {2'b00, v[5:0]};
      end
      ADDR_NR12: begin
        env_cfg[0] = v; env_cnt[0] = v[2:0]; env_lvl[0] = v[7:4];
      end
      ADDR_NR13: freq[0][7:0] = v;
      ADDR_NR14: begin
        // high frequency bits only land on a trigger
        if (v[7]) begin
          chan_on[0] = 1'b1;
          len_cnt[0] = 8'd63;
          freq[0][10:8] = v[2:0];
          sweep_shadow = {1'b0, freq[0]};
          sweep_tmr = sweep_cfg[6:4];
          if ((sweep_cfg & 7'h77) != 0) sweep_on = 1'b1;
        end
        len_en[0] = v[6];
      end
      ADDR_NR21: begin
        duty[1] = v[7:6];
        len_cnt[1] = {2'b00, v[5:0]};
      end
      ADDR_NR22: begin
        env_cfg[1] = v; env_cnt[1] = v[2:0]; env_lvl[1] = v[7:4];
      end
      ADDR_NR23: freq[1][7:0] = v;
      ADDR_NR24: begin
        if (v[7]) begin
          chan_on[1] = 1'b1;
          len_cnt[1] = 8'd63;
        end
        len_en[1] = v[6];
        freq[1][10:8] = v[2:0];
      end
      ADDR_NR30: chan_on[2] = (v != 0);
      ADDR_NR31: len_cnt[2] = v;
      ADDR_NR32: wave_lvl = v[6:5];
      ADDR_NR33: freq[2][7:0] = v;
      ADDR_NR34: begin
        if (v[7]) begin
          chan_on[2] = 1'b1;
          len_cnt[2] = 8'hFF;
        end
        len_en[2] = v[6];
        freq[2][10:8] = v[2:0];
      end
      ADDR_NR41: len_cnt[3] = v;
      ADDR_NR42: begin
        env_cfg[2] = v; env_cnt[2] = v[2:0]; env_lvl[2] = v[7:4];
      end
      ADDR_NR43: noise_cfg = v;
      ADDR_NR44: begin
        if (v[7]) begin
          chan_on[3] = 1'b1;
          len_cnt[3] = 8'hFF;
        end
        len_en[3] = v[6];
      end
      ADDR_NR50: speaker = v;
      ADDR_NR51: routing = v;
      default: begin
        if (a >= ADDR_WAVE && a < ADDR_WAVE + 8'd16) wave_mem[a - ADDR_WAVE] = v;
      end
    endcase
  endfunction

  function automatic logic [7:0] read_register(logic [7:0] a);
    logic [7:0] r;
    if (a == ADDR_NR52) begin
      r = {master_en, 7'd0};
      for (int c = 0; c < 4; c++) if (len_cnt[c] != 0) r[c] = 1'b1;
      return r;
    end
    if (!master_en) return 8'h00;
    case (a)
      ADDR_NR10: return {1'b0, sweep_cfg};
      ADDR_NR11: return {duty[0], 6'h3F};
      ADDR_NR12: return env_cfg[0];
      ADDR_NR13: return 8'hFF;
      ADDR_NR14: return {1'b1, len_en[0], 6'h3F};
      ADDR_NR21: return {duty[1], 6'h3F};
      ADDR_NR22: return env_cfg[1];
      ADDR_NR23: return 8'hFF;
      ADDR_NR24: return {1'b1, len_en[1], 6'h3F};
      ADDR_NR30: return {7'h7F, chan_on[2]};
      ADDR_NR31: return len_cnt[2];
      ADDR_NR32: return {1'b1, wave_lvl, 5'h1F};
      ADDR_NR33: return 8'hFF;
      ADDR_NR34: return {1'b1, len_en[2], 6'h3F};
      ADDR_NR41: return len_cnt[3];
      ADDR_NR42: return env_cfg[2];
      ADDR_NR43: return noise_cfg;
      ADDR_NR44: return {1'b1, len_en[3], 6'h3F};
      ADDR_NR50: return speaker;
      ADDR_NR51: return routing;
      default: begin
        if (a >= ADDR_WAVE && a < ADDR_WAVE + 8'd16) return wave_mem[a - ADDR_WAVE];
        return 8'h00;
      end
    endcase
  endfunction

  // Apply one transaction to the shadow state and form the result it must produce
  function automatic result_t predict_apu(item_t it);
    result_t r;
    r = '0;
    case (req_t'(it.req_type))
      REQ_WRITE: write_register(it.reg_address, it.write_data);
      REQ_READ:  r.read_data = read_register(it.reg_address);
      REQ_TICK:  if (master_en) tick_time(it.tick_cycles);
      default: ;
    endcase
    r.channel_enabled   = {chan_on[3], chan_on[2], chan_on[1], chan_on[0]};
    r.square1_volume    = env_lvl[0];
    r.square2_volume    = env_lvl[1];
    r.noise_volume      = env_lvl[2];
    r.square1_frequency = freq[0];
    r.square2_frequency = freq[1];
    r.wave_frequency    = freq[2];
    r.square_duty_codes = {duty[1], duty[0]};
    r.wave_level_code   = wave_lvl;
    r.noise_settings    = noise_cfg;
    r.mix_enables       = routing;
    return r;
  endfunction

  // Drive one transaction, hold it until accepted, then maybe open a gap
  task automatic send_item(req_t kind, logic [7:0] addr, logic [7:0] data,
                           logic [7:0] cyc);
    item_t it;
    int    gap;
    it.req_type = kind;
    it.reg_address = addr;
    it.write_data = data;
    it.tick_cycles = cyc;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(predict_apu(it));
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frame_len(logic [15:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    frame_len = v;
  endtask

  // Receiver: alternate between free-flowing, light and heavy stall windows
  int stall_mode;
  int stall_window;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
      stall_window <= 0;
    end else begin
      if (stall_window == 0) begin
        stall_mode   <= $urandom_range(0, 2);
        stall_window <= $urandom_range(10, 80);
      end else begin
        stall_window <= stall_window - 1;
      end
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Checker: compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending");
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("read_data", exp_r.read_data, got.read_data);
        check_field("channel_enabled", exp_r.channel_enabled, got.channel_enabled);
        check_field("square1_volume", exp_r.square1_volume, got.square1_volume);
        check_field("square2_volume", exp_r.square2_volume, got.square2_volume);
        check_field("noise_volume", exp_r.noise_volume, got.noise_volume);
        check_field("square1_frequency", exp_r.square1_frequency, got.square1_frequency);
        check_field("square2_frequency", exp_r.square2_frequency, got.square2_frequency);
        check_field("wave_frequency", exp_r.wave_frequency, got.wave_frequency);
        check_field("square_duty_codes", exp_r.square_duty_codes, got.square_duty_codes);
        check_field("wave_level_code", exp_r.wave_level_code, got.wave_level_code);
        check_field("noise_settings", exp_r.noise_settings, got.noise_settings);
        check_field("mix_enables", exp_r.mix_enables, got.mix_enables);
      end
    end
  end

  // Write and read back each mapped register but NR52, and the first and last wave RAM bytes; poke holes
  task automatic test_register_file();
    for (int i = 0; i < 20; i++) begin
      send_item(REQ_WRITE, reg_map[i], 8'($urandom), 8'($urandom));
      send_item(REQ_READ, reg_map[i], 8'($urandom), 8'($urandom));
    end
    send_item(REQ_WRITE, ADDR_WAVE, 8'hFF, 8'h00);
    send_item(REQ_WRITE, ADDR_WAVE + 8'd15, 8'h00, 8'hFF);
    send_item(REQ_READ, ADDR_WAVE, 8'h00, 8'h00);
    send_item(REQ_READ, ADDR_WAVE + 8'd15, 8'h00, 8'h00);
    // unmapped holes and the unused request code
    send_item(REQ_WRITE, 8'h15, 8'hA5, 8'h00);
    send_item(REQ_READ, 8'h15, 8'h00, 8'h00);
    send_item(REQ_READ, 8'hFF, 8'h00, 8'h00);
    send_item(REQ_NONE, ADDR_NR51, 8'h00, 8'hFF);
    send_item(REQ_READ, ADDR_NR52, 8'h00, 8'h00);
  endtask

  // Master off: writes dropped, reads zero, ticks frozen, status still live
  task automatic test_master_off();
    send_item(REQ_WRITE, ADDR_NR52, 8'h7F, 8'h00);
    send_item(REQ_WRITE, ADDR_NR50, 8'h5A, 8'h00);
    send_item(REQ_READ, ADDR_NR50, 8'h00, 8'h00);
    send_item(REQ_TICK, 8'h00, 8'h00, 8'hFF);
    send_item(REQ_READ, ADDR_NR52, 8'h00, 8'h00);
    send_item(REQ_WRITE, ADDR_NR52, 8'h80, 8'h00);
    send_item(REQ_READ, ADDR_NR50, 8'h00, 8'h00);
  endtask

  // Fast frame clock: sweep overflow, envelopes up/down/frozen, length expiry
  task automatic test_frame_sequencer();
    write_frame_len(16'd1);
    send_item(REQ_WRITE, ADDR_NR10, 8'h11, 8'h00);
    send_item(REQ_WRITE, ADDR_NR13, 8'hFF, 8'h00);
    send_item(REQ_WRITE, ADDR_NR14, 8'hC7, 8'h00);
    send_item(REQ_WRITE, ADDR_NR12, 8'hF1, 8'h00);
    send_item(REQ_WRITE, ADDR_NR22, 8'h09, 8'h00);
    send_item(REQ_WRITE, ADDR_NR42, 8'h80, 8'h00);
    send_item(REQ_WRITE, ADDR_NR21, 8'h82, 8'h00);
    send_item(REQ_WRITE, ADDR_NR24, 8'h47, 8'h00);
    send_item(REQ_WRITE, ADDR_NR31, 8'h03, 8'h00);
    send_item(REQ_WRITE, ADDR_NR34, 8'h40, 8'h00);
    send_item(REQ_WRITE, ADDR_NR44, 8'hC0, 8'h00);
    send_item(REQ_TICK, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 24; i++) send_item(REQ_TICK, 8'h00, 8'h00, 8'd2);
    send_item(REQ_READ, ADDR_NR52, 8'h00, 8'h00);
    write_frame_len(16'hFFFF);
    for (int i = 0; i < 4; i++) send_item(REQ_TICK, 8'h00, 8'h00, 8'hFF);
  endtask

  function automatic logic [7:0] pick_address();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return reg_map[$urandom_range(0, 19)];
    if (sel < 85) return ADDR_WAVE + 8'($urandom_range(0, 15));
    if (sel < 90) return ADDR_NR52;
    return 8'($urandom);
  endfunction

  // Random traffic in phases with different frame lengths
  task automatic test_random_traffic();
    logic [15:0] lens [4] = '{16'd3, 16'd40, 16'd1, 16'd8192};
    int          sel;
    logic [7:0]  addr;
    logic [7:0]  data;
    for (int p = 0; p < 4; p++) begin
      write_frame_len((p == 1) ? 16'($urandom_range(4, 300)) : lens[p]);
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        sel = $urandom_range(0, 99);
        addr = pick_address();
        data = 8'($urandom);
        // keep the unit powered most of the time so the sequencer runs
        if (addr == ADDR_NR52 && $urandom_range(0, 3) != 0) data[7] = 1'b1;
        if (sel < 40) send_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (sel < 72) send_item(REQ_WRITE, addr, data, 8'($urandom));
        else if (sel < 96) send_item(REQ_READ, addr, data, 8'($urandom));
        else send_item(REQ_NONE, addr, data, 8'($urandom));
        // hold off once per phase until everything in flight has returned
        if (i == 60) drain_results();
      end
    end
  endtask

  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    rst_n        <= 1'b0;
    cycle_count  = 0;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    burst_left   = 0;
    seq_steps_seen = 0;
    reset_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_file();
    test_master_off();
    test_frame_sequencer();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d transactions (%0d results) over five frame lengths,",
             items_sent, results_seen);
    $display("with %0d frame sequencer steps, master off/on and stalls on both sides.",
             seq_steps_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
src/apu_pkg.sv
src/apu_stream_if.sv
src/apu_envelope.sv
src/apu_register_frame_sequencer.sv
tb/sv/testbench.sv
